/* src/assert_macros.svh */
// assertion macros used by the scanner checker
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* src/fdss_pkg.sv */
// types, constants and the segment decoder of the four-digit scanner
// no dependencies
package fdss_pkg;

  typedef enum logic [0:0] {
    OpLoad = 1'b0,
    OpTick = 1'b1
  } fdss_op_e;

  typedef struct packed {
    fdss_op_e    opcode;
    logic [13:0] display_value;
  } fdss_in_t;

  typedef struct packed {
    logic [6:0] segments;
    logic [3:0] digit_select;
  } fdss_out_t;

  localparam logic [13:0] MaxShown  = 14'd9999;
  localparam logic [3:0]  MinSlots  = 4'd4;
  localparam logic [3:0]  SlotsRst  = 4'd8;
  localparam logic [3:0]  SelNone   = 4'b1111;

  // bit0 = a .. bit6 = g, 1 = lit
  function automatic logic [6:0] seg_of(input logic [3:0] digit);
    logic [6:0] seg;
    case (digit)
      4'd0:    seg = 7'h3F;
      4'd1:    seg = 7'h06;
      4'd2:    seg = 7'h5B;
      4'd3:    seg = 7'h4F;
      4'd4:    seg = 7'h66;
      4'd5:    seg = 7'h6D;
      4'd6:    seg = 7'h7D;
      4'd7:    seg = 7'h07;
      4'd8:    seg = 7'h7F;
      4'd9:    seg = 7'h6F;
      default: seg = 7'h00;
    endcase
    return seg;
  endfunction

endpackage

/* src/four_digit_seven_segment_scanner.sv */
// top level of the four-digit multiplexed seven-segment scanner
// depends on fdss_pkg
//
// Four-digit common-cathode display driver. A load transaction (opcode
// OpLoad) stores a value, saturated to 9999; a tick transaction (OpTick)
// advances the scan slot. Slots 1..4 drive thousands, hundreds, tens and
// units in turn (active-low select, bit0 = thousands) with that digit's
// segment pattern; slots 5 up to scan_slots hold the last digit lit, then
// the counter wraps to slot 1. scan_slots below 4 acts as 4. The first tick
// after reset only advances the counter. Every transaction returns exactly
// one result with the current segment and select outputs. Throughput is one
// transaction per clock unless a held result is stalled, the only case in
// which the input is stalled; the decode is single-pass logic between the
// input port and the result register. The user must write scan_slots through
// cfg_we_i/cfg_wdata_i only while the block idles; the block has no check.
module four_digit_seven_segment_scanner (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fdss_pkg::fdss_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fdss_pkg::fdss_out_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [3:0]         cfg_wdata_i
);
  import fdss_pkg::*;

  // slot codes of the four digits
  localparam logic [3:0] SlotThou = 4'd1;
  localparam logic [3:0] SlotHund = 4'd2;
  localparam logic [3:0] SlotTens = 4'd3;
  localparam logic [3:0] SlotUnit = 4'd4;

  // configuration
  logic [3:0] scan_slots_q;

  // shown value kept with its quotients by 1000, 100 and 10
  logic [13:0] val_q, val_d;
  logic [3:0]  q1000_q, q1000_d;
  logic [6:0]  q100_q, q100_d;
  logic [9:0]  q10_q, q10_d;

  // scan state and display registers
  logic [3:0] slot_q, slot_d;
  logic [6:0] seg_q, seg_d;
  logic [3:0] sel_q, sel_d;
  logic       out_valid_q, out_valid_d;

  logic accept;

  // handshake: a held result blocks the input only while it is stalled
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  // load path: saturate, then divide by constants through reciprocals.
  // each reciprocal is rounded up and exact over 0..9999
  logic [13:0] sat_val;
  logic [27:0] prod1000;
  logic [26:0] prod100;
  logic [26:0] prod10;

  assign sat_val  = (in_data_i.display_value > MaxShown) ? MaxShown
                                                          : in_data_i.display_value;
  assign prod1000 = {14'd0, sat_val} * 28'd16778;   // 2^24 / 1000
  assign prod100  = {13'd0, sat_val} * 27'd10486;   // 2^20 / 100
  assign prod10   = {13'd0, sat_val} * 27'd13108;   // 2^17 / 10

  // tick path: hundreds and tens from one small reciprocal and a times-ten subtract, units from a subtract
  logic [14:0] q100_div;    // q100 * 205, 2^11 / 10
  logic [3:0]  hund_q10;
  logic [6:0]  hund_rem;
  logic [17:0] q10_div;     // q10 * 205, 2^11 / 10, exact up to 999
  logic [6:0]  tens_q10;
  logic [9:0]  tens_rem;
  logic [13:0] unit_rem;
  logic [3:0]  digit;

  assign q100_div = {8'd0, q100_q} * 15'd205;
  assign hund_q10 = q100_div[14:11];
  assign hund_rem = q100_q - ({3'd0, hund_q10} * 7'd10);

  assign q10_div  = {8'd0, q10_q} * 18'd205;
  assign tens_q10 = q10_div[17:11];
  assign tens_rem = q10_q - ({3'd0, tens_q10} * 10'd10);

  assign unit_rem = val_q - ({4'd0, q10_q} * 14'd10);

  // scan length and slot advance
  logic [3:0] scan_len;
  logic [4:0] slot_inc;

  assign scan_len = (scan_slots_q < MinSlots) ? MinSlots : scan_slots_q;
  assign slot_inc = {1'b0, slot_q} + 5'd1;

  always_comb begin
    val_d   = val_q;
    q1000_d = q1000_q;
    q100_d  = q100_q;
    q10_d   = q10_q;
    slot_d  = slot_q;
    seg_d   = seg_q;
    sel_d   = sel_q;
    digit   = q1000_q;
    // which digit this slot shows
    case (slot_q)
      SlotThou: digit = q1000_q;
      SlotHund: digit = hund_rem[3:0];
      SlotTens: digit = tens_rem[3:0];
      SlotUnit: digit = unit_rem[3:0];
      default:  digit = q1000_q;
    endcase
    if (accept) begin
      case (in_data_i.opcode)
        OpLoad: begin
          val_d   = sat_val;
          q1000_d = prod1000[27:24];
          q100_d  = prod100[26:20];
          q10_d   = prod10[26:17];
        end
        OpTick: begin
          // digit slots latch a new pattern; later slots hold the last one
          case (slot_q)
            SlotThou: begin
              sel_d = 4'b1110;
              seg_d = seg_of(digit);
            end
            SlotHund: begin
              sel_d = 4'b1101;
              seg_d = seg_of(digit);
            end
            SlotTens: begin
              sel_d = 4'b1011;
              seg_d = seg_of(digit);
            end
            SlotUnit: begin
              sel_d = 4'b0111;
              seg_d = seg_of(digit);
            end
            default: begin
              sel_d = sel_q;
            end
          endcase
          // wrap to slot one past the scan length, also when it was lowered
          slot_d = (slot_inc > {1'b0, scan_len}) ? SlotThou : slot_inc[3:0];
        end
        default: begin
          slot_d = slot_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_slots_q <= SlotsRst;
      val_q        <= '0;
      q1000_q      <= '0;
      q100_q       <= '0;
      q10_q        <= '0;
      slot_q       <= '0;
      seg_q        <= '0;
      sel_q        <= SelNone;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        scan_slots_q <= cfg_wdata_i;
      end
      val_q       <= val_d;
      q1000_q     <= q1000_d;
      q100_q      <= q100_d;
      q10_q       <= q10_d;
      slot_q      <= slot_d;
      seg_q       <= seg_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // display registers are the result; they only move on an accepted transaction
  assign out_valid_o             = out_valid_q;
  assign out_data_o.segments     = seg_q;
  assign out_data_o.digit_select = sel_q;

endmodule

/* src/fdss_checker.sv */
// port-level checker of the four-digit scanner and its bind
// depends on fdss_pkg and assert_macros.svh
`include "assert_macros.svh"

module fdss_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input fdss_pkg::fdss_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input fdss_pkg::fdss_out_t out_data_o
);
  import fdss_pkg::*;

  logic in_acc;
  logic sel_none;
  logic sel_one;

  assign in_acc   = in_valid_i & ~in_stall_o;
  assign sel_none = (out_data_o.digit_select == SelNone);
  assign sel_one  = $onehot(~out_data_o.digit_select);

  // stalled result stays put
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
               out_valid_o && $stable(out_data_o))
  // every accepted transaction yields a result next cycle
  `ASSERT_NEXT(a_acc_result, clk_i, rst_ni, in_acc, out_valid_o)
  // at most one digit driven at a time
  `ASSERT_IMPL(a_sel_shape, clk_i, rst_ni, out_valid_o, sel_none || sel_one)
  // dark until the first digit is scanned
  `ASSERT_IMPL(a_dark_idle, clk_i, rst_ni, sel_none, out_data_o.segments == 7'd0)
  // a load never disturbs what is shown
  `ASSERT_NEXT(a_load_quiet, clk_i, rst_ni, in_acc && (in_data_i.opcode == OpLoad),
               out_data_o == $past(out_data_o))

endmodule

bind four_digit_seven_segment_scanner fdss_checker u_fdss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

/* sim/four_digit_seven_segment_scanner_test.sv */
// testbench for the four-digit seven-segment scanner: directed and random load/tick
// transactions checked against a cycle-free prediction of the scan state
// depends on fdss_pkg and four_digit_seven_segment_scanner
module four_digit_seven_segment_scanner_test;

  import fdss_pkg::*;

  // digit patterns 0..9, digit d sits at bits [7*d +: 7]
  localparam logic [69:0] DigitPatterns = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                           7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};
  // scan lengths per phase, phase p at bits [4*p +: 4]; below-minimum and both extremes
  localparam int          NumSettings   = 10;
  localparam logic [39:0] ScanSettings  = {4'd4, 4'd5, 4'd15, 4'd12, 4'd1,
                                           4'd9, 4'd3, 4'd0, 4'd15, 4'd4};
  localparam int          ItemsPerPhase = 145;
  localparam int          CycleLimit    = 300000;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid  = 1'b0;
  fdss_in_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      cfg_we    = 1'b0;
  logic [3:0] cfg_wdata = 4'd0;
  logic      in_stall;
  logic      out_valid;
  fdss_out_t out_data;

  // transactions waiting to be driven, and display outputs still to come back
  fdss_in_t  pending_items[$];
  fdss_out_t display_outputs_q[$];

  // shadow of the scanner state
  logic [13:0] pred_value = 14'd0;
  logic [3:0]  pred_slot  = 4'd0;
  logic [3:0]  pred_len   = SlotsRst;
  logic [6:0]  pred_seg   = 7'd0;
  logic [3:0]  pred_sel   = SelNone;

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  int  gap_left       = 0;
  int  stall_left     = 0;
  // when low both sides run without gaps or stalls
  logic idle_enabled  = 1'b1;

  four_digit_seven_segment_scanner dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #10 clk_i = ~clk_i;

  // advance the shadow state by one accepted transaction, return what the display shows
  function automatic fdss_out_t scan_display_step(input fdss_in_t item);
    fdss_out_t   shown;
    logic [4:0]  next_slot;
    logic [3:0]  len;
    int unsigned digit;
    if (item.opcode == OpLoad) begin
      // loads only change the stored value, saturated at 9999
      pred_value = (item.display_value > MaxShown) ? MaxShown : item.display_value;
    end else begin
      len = (pred_len < MinSlots) ? MinSlots : pred_len;
      // slots 1..4 latch one digit, thousands first; later slots hold the last one
      if (pred_slot >= 4'd1 && pred_slot <= 4'd4) begin
        pred_sel = SelNone & ~(4'b0001 << (pred_slot - 4'd1));
        case (pred_slot)
          4'd1:    digit = pred_value / 1000;
          4'd2:    digit = (pred_value % 1000) / 100;
          4'd3:    digit = (pred_value % 100) / 10;
          default: digit = pred_value % 10;
        endcase
        pred_seg = DigitPatterns[digit*7 +: 7];
      end
      // wrap to slot one past the scan length, also when the length shrank below the slot
      next_slot = {1'b0, pred_slot} + 5'd1;
      if (next_slot > {1'b0, len}) next_slot = 5'd1;
      pred_slot = next_slot[3:0];
    end
    shown.segments     = pred_seg;
    shown.digit_select = pred_sel;
    return shown;
  endfunction

  task automatic queue_item(input fdss_op_e op, input logic [13:0] value);
    fdss_in_t item;
    item.opcode        = op;
    item.display_value = value;
    pending_items.push_back(item);
  endtask

  // mostly ticks, loads spread over in-range, saturating and edge values
  task automatic queue_random_items(input int count);
    fdss_in_t    item;
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      item.opcode = ($urandom_range(0, 99) < 70) ? OpTick : OpLoad;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        item.display_value = 14'($urandom_range(0, 9999));
      end else if (pick < 75) begin
        item.display_value = 14'($urandom_range(10000, 16383));
      end else if (pick < 85) begin
        case ($urandom_range(0, 3))
          0:       item.display_value = 14'd0;
          1:       item.display_value = 14'd9999;
          2:       item.display_value = 14'd10000;
          default: item.display_value = 14'd16383;
        endcase
      end else begin
        item.display_value = 14'($urandom);
      end
      pending_items.push_back(item);
    end
  endtask

  // sampled on the falling edge so every update of the rising edge has settled
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid || display_outputs_q.size() != 0);
    // extra margin after the last result
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_scan_slots(input logic [3:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    pred_len = value;
  endtask

  // driver: presents pending transactions, with a random gap before each one
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    fdss_in_t next_item;
    logic     next_valid;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      gap_left = 0;
    end else begin
      next_valid = in_valid;
      next_item  = in_data;
      // transaction accepted: record what the display should show afterwards
      if (in_valid && !in_stall) begin
        display_outputs_q.push_back(scan_display_step(in_data));
        next_valid = 1'b0;
      end
      if (!next_valid && pending_items.size() != 0) begin
        if (gap_left != 0) begin
          gap_left--;
        end else begin
          next_item  = pending_items.pop_front();
          next_valid = 1'b1;
          gap_left   = idle_enabled ? $urandom_range(0, 4) : 0;
        end
      end
      // one assignment each, so a valid held for back-to-back items never dips
      in_valid <= next_valid;
      in_data  <= next_item;
    end
  end

  // monitor: takes results after a random stall and checks them in order
  always @(posedge clk_i or negedge rst_ni) begin : monitor_proc
    fdss_out_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (display_outputs_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: segments %h select %b", out_data.segments,
                     out_data.digit_select);
        end else begin
          want = display_outputs_q.pop_front();
          if (out_data.segments !== want.segments ||
              out_data.digit_select !== want.digit_select) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: segments exp %h got %h, select exp %b got %b",
                       want.segments, out_data.segments, want.digit_select,
                       out_data.digit_select);
          end
        end
        stall_left = idle_enabled ? $urandom_range(0, 4) : 0;
      end else if (out_valid && stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // run time guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    logic [3:0] setting;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part at the reset scan length of eight slots:
    // first tick after reset only advances, saturation, hold slots and wrap
    queue_item(OpTick, 14'd0);
    queue_item(OpLoad, 14'd0);
    queue_item(OpTick, 14'd0);
    queue_item(OpLoad, 14'd16383);
    queue_item(OpTick, 14'd0);
    queue_item(OpTick, 14'd0);
    queue_item(OpTick, 14'd0);
    queue_item(OpLoad, 14'd10000);
    // slots five to eight keep the units digit lit, then wrap to thousands
    repeat (5) queue_item(OpTick, 14'h3FFF);
    queue_item(OpLoad, 14'd1234);
    queue_item(OpTick, 14'd0);
    queue_item(OpTick, 14'd0);
    queue_item(OpLoad, 14'd5678);
    queue_item(OpTick, 14'd0);
    queue_item(OpTick, 14'd0);
    queue_item(OpLoad, 14'd9999);
    queue_item(OpTick, 14'd0);
    queue_item(OpTick, 14'd0);
    wait_idle();

    // random phases, each at its own scan length; some run without idling
    for (int p = 0; p < NumSettings + 2; p++) begin
      setting = (p < NumSettings) ? ScanSettings[p*4 +: 4] : 4'($urandom_range(0, 15));
      idle_enabled = (p % 4 != 2);
      write_scan_slots(setting);
      queue_random_items(ItemsPerPhase);
      wait_idle();
      // at the longest scan, park the counter high so the next shorter length
      // has to wrap from a slot beyond its end
      if (pred_len == 4'd15) begin
        while (pred_slot < 4'd10) begin
          queue_item(OpTick, 14'($urandom));
          wait_idle();
        end
      end
    end
    idle_enabled = 1'b1;

    wait_idle();
    if (mismatch_count == 0 && display_outputs_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
